@@ rtl/core/huffman_bit_packer_assert.svh @@
// Assertion macros for the bit packer.
`ifndef HUFFMAN_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_BIT_PACKER_ASSERT_SVH

// Same-cycle implication, disabled while en is low.
`define HUF_ASSERT_SAME(label, clk, en, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(en)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while en is low.
`define HUF_ASSERT_NEXT(label, clk, en, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(en)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/huf_pkg.sv @@
package huf_pkg;

  localparam int ACT_W       = 2;
  localparam int SYM_W       = 8;
  localparam int LEN_W       = 6;
  localparam int CODE_BITS   = 32;
  localparam int BYTE_W      = 8;
  localparam int PAD_W       = 3;
  localparam int PEND_W      = 7;
  localparam int STREAM_W    = PEND_W + 1 + CODE_BITS;
  localparam int TABLE_DEPTH = 256;

  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ENC   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FLUSH = 2'd2;

  typedef logic [ACT_W-1:0]  act_t;
  typedef logic [SYM_W-1:0]  sym_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [PAD_W-1:0]  pad_t;

endpackage

@@ rtl/core/huf_ifs.sv @@
interface huf_in_if;
  logic            valid;
  logic            ready;
  huf_pkg::act_t   action;
  huf_pkg::sym_t   symbol;
  huf_pkg::len_t   code_len;
  logic [huf_pkg::CODE_BITS-1:0] code_bits;

  modport source (output valid, action, symbol, code_len, code_bits, input ready);
  modport sink   (input valid, action, symbol, code_len, code_bits, output ready);
  modport mon    (input valid, action, symbol, code_len, code_bits, ready);
endinterface

interface huf_out_if;
  logic            valid;
  logic            ready;
  huf_pkg::byte_t  out_byte;
  logic            last_of_run;
  huf_pkg::pad_t   pad_bits;

  modport source (output valid, out_byte, last_of_run, pad_bits, input ready);
  modport sink   (input valid, out_byte, last_of_run, pad_bits, output ready);
  modport mon    (input valid, out_byte, last_of_run, pad_bits, ready);
endinterface

@@ rtl/core/huffman_bit_packer.sv @@
// Path: a taken word goes through the table read register, then the emit register.
// Throughput: one input word per cycle unless the stage stalls; a word yielding k bytes
//   holds the output register until popped; back-pressure: multi-byte codes, out_ready.
// Per-cycle loop: code lookup result plus the bit buffer merge in one stage.
// Reset: synchronous, active low; clears the bit buffer, the pipeline and the 256
//   table valid flags at once (no clearing sweep), so unloaded symbols read as absent.
module huffman_bit_packer #(
  parameter int MAX_CODE_LEN = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  huf_in_if.sink     in_chan,
  huf_out_if.source  out_chan
);

  localparam int LEN_CAP = (MAX_CODE_LEN < huf_pkg::CODE_BITS) ? MAX_CODE_LEN
                                                                : huf_pkg::CODE_BITS;
  localparam int CODE_W  = LEN_CAP;
  localparam int ENT_W   = CODE_W + huf_pkg::LEN_W;
  localparam int EMIT_W  = huf_pkg::STREAM_W - huf_pkg::BYTE_W;
  localparam int SW      = huf_pkg::STREAM_W;
  localparam int PW      = huf_pkg::PEND_W;

  // code table, code stored left aligned
  logic [ENT_W-1:0]              mem [huf_pkg::TABLE_DEPTH];
  logic [huf_pkg::TABLE_DEPTH-1:0] tvalid_r;

  logic                  in_acc;
  huf_pkg::len_t         len_cap;
  logic [huf_pkg::CODE_BITS-1:0] code_full;

  logic                  s1_valid_r;
  logic                  s1_flush_r;
  logic                  rd_ok_r;
  logic [ENT_W-1:0]      rd_ent_r;

  logic [PW-1:0]         pend_r;
  logic [2:0]            pcnt_r;

  logic [EMIT_W-1:0]     emit_data_r;
  logic [2:0]            emit_cnt_r;
  huf_pkg::pad_t         emit_pad_r;

  huf_pkg::len_t         eff_len;
  logic [huf_pkg::CODE_BITS-1:0] code32;
  logic [SW-1:0]         stream;
  logic [SW-1:0]         shifted;
  huf_pkg::len_t         total;
  logic [2:0]            s1_nb;
  logic [EMIT_W-1:0]     s1_data;
  huf_pkg::pad_t         s1_pad;
  logic [PW-1:0]         pend_nxt;
  logic [2:0]            pcnt_nxt;
  logic                  emit_free;
  logic                  s1_adv;
  logic                  pop;

  assign in_acc = in_chan.valid && in_chan.ready;

  always_comb begin
    len_cap = (in_chan.code_len > huf_pkg::LEN_W'(LEN_CAP)) ? huf_pkg::LEN_W'(LEN_CAP)
                                                           : in_chan.code_len;
    code_full = in_chan.code_bits << (huf_pkg::LEN_W'(huf_pkg::CODE_BITS) - len_cap);
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_chan.action == huf_pkg::ACT_LOAD) begin
      mem[in_chan.symbol] <= {len_cap, code_full[huf_pkg::CODE_BITS-1 -: CODE_W]};
    end
    if (in_acc) begin
      rd_ent_r <= mem[in_chan.symbol];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tvalid_r   <= '0;
      s1_valid_r <= 1'b0;
      s1_flush_r <= 1'b0;
      rd_ok_r    <= 1'b0;
    end else begin
      if (in_acc && in_chan.action == huf_pkg::ACT_LOAD) begin
        tvalid_r[in_chan.symbol] <= 1'b1;
      end
      if (in_acc) begin
        s1_valid_r <= (in_chan.action == huf_pkg::ACT_ENC) ||
                      (in_chan.action == huf_pkg::ACT_FLUSH);
        s1_flush_r <= (in_chan.action == huf_pkg::ACT_FLUSH);
        rd_ok_r    <= tvalid_r[in_chan.symbol];
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // merge code into bit buffer, or on flush emit the pending bits with padding
  always_comb begin
    eff_len  = rd_ok_r ? rd_ent_r[ENT_W-1 -: huf_pkg::LEN_W] : '0;
    code32   = rd_ok_r ? (huf_pkg::CODE_BITS'(rd_ent_r[CODE_W-1:0])
                          << (huf_pkg::CODE_BITS - CODE_W)) : '0;
    stream   = {pend_r, {(SW-PW){1'b0}}} |
               (SW'({code32, {huf_pkg::BYTE_W{1'b0}}}) >> pcnt_r);
    total    = huf_pkg::LEN_W'(pcnt_r) + eff_len;
    if (s1_flush_r) begin
      s1_nb    = (pcnt_r != 3'd0) ? 3'd1 : 3'd0;
      s1_data  = {pend_r, {(EMIT_W-PW){1'b0}}};
      s1_pad   = huf_pkg::PAD_W'(4'd8 - {1'b0, pcnt_r});
      shifted  = '0;
      pend_nxt = '0;
      pcnt_nxt = '0;
    end else begin
      s1_nb    = total[5:3];
      s1_data  = stream[SW-1 -: EMIT_W];
      s1_pad   = '0;
      shifted  = stream << {s1_nb, 3'b000};
      pend_nxt = shifted[SW-1 -: PW];
      pcnt_nxt = total[2:0];
    end
  end

  assign pop       = (emit_cnt_r != 3'd0) && out_chan.ready;
  assign emit_free = (emit_cnt_r == 3'd0) || ((emit_cnt_r == 3'd1) && out_chan.ready);
  assign s1_adv    = s1_valid_r && ((s1_nb == 3'd0) || emit_free);
  assign in_chan.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= '0;
      pcnt_r     <= '0;
      emit_cnt_r <= '0;
    end else begin
      if (s1_adv) begin
        pend_r <= pend_nxt;
        pcnt_r <= pcnt_nxt;
      end
      if (s1_adv && s1_nb != 3'd0) begin
        emit_cnt_r <= s1_nb;
      end else if (pop) begin
        emit_cnt_r <= emit_cnt_r - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_nb != 3'd0) begin
      emit_data_r <= s1_data;
      emit_pad_r  <= s1_pad;
    end else if (pop) begin
      emit_data_r <= emit_data_r << huf_pkg::BYTE_W;
    end
  end

  assign out_chan.valid       = (emit_cnt_r != 3'd0);
  assign out_chan.out_byte    = emit_data_r[EMIT_W-1 -: huf_pkg::BYTE_W];
  assign out_chan.last_of_run = (emit_cnt_r == 3'd1);
  assign out_chan.pad_bits    = emit_pad_r;

endmodule

@@ rtl/core/huf_chk.sv @@
`include "huffman_bit_packer_assert.svh"

module huf_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input huf_pkg::byte_t out_byte,
  input logic           out_last,
  input huf_pkg::pad_t  out_pad
);

  `HUF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `HUF_ASSERT_NEXT(a_byte_hold, clk, rst_n, out_valid && !out_ready, $stable(out_byte))
  `HUF_ASSERT_SAME(a_pad_last, clk, rst_n, out_valid && out_pad != 3'd0, out_last)
  `HUF_ASSERT_NEXT(a_rst_idle, clk, 1'b1, !rst_n, !out_valid && in_ready)

endmodule

bind huffman_bit_packer huf_chk u_huf_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_byte  (out_chan.out_byte),
  .out_last  (out_chan.last_of_run),
  .out_pad   (out_chan.pad_bits)
);
